>>> rtl/owts_pkg.sv
// ---------------------------------------------------------------------------
// owts_pkg: shared types and constants of the one-wire temperature sequencer
// Transfer payloads, register file layout, phase encoding and command codes.
// ---------------------------------------------------------------------------
`default_nettype none

package owts_pkg;

   localparam int REG_COUNT = 7;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int CONV_W    = 20;

   localparam logic [2:0] REG_RESET_LOW     = 3'd0;
   localparam logic [2:0] REG_PRES_TIMEOUT  = 3'd1;
   localparam logic [2:0] REG_PRES_RECOVERY = 3'd2;
   localparam logic [2:0] REG_SLOT          = 3'd3;
   localparam logic [2:0] REG_READ_SAMPLE   = 3'd4;
   localparam logic [2:0] REG_SHORT_LOW     = 3'd5;
   localparam logic [2:0] REG_CONV_WAIT     = 3'd6;

   localparam logic [9:0]        RST_RESET_LOW     = 10'd700;
   localparam logic [9:0]        RST_PRES_TIMEOUT  = 10'd200;
   localparam logic [9:0]        RST_PRES_RECOVERY = 10'd700;
   localparam logic [7:0]        RST_SLOT          = 8'd60;
   localparam logic [5:0]        RST_READ_SAMPLE   = 6'd12;
   localparam logic [3:0]        RST_SHORT_LOW     = 4'd2;
   localparam logic [CONV_W-1:0] RST_CONV_WAIT     = 20'd700;

   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_READ     = 2'd1;
   localparam logic [1:0] ACT_PRESENCE = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_PRES  = 2'd1;
   localparam logic [1:0] STATUS_PRES_LONG = 2'd2;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   localparam logic [2:0] STEP_NONE      = 3'd0;
   localparam logic [2:0] STEP_SKIP_1    = 3'd1;
   localparam logic [2:0] STEP_CONVERT   = 3'd2;
   localparam logic [2:0] STEP_CONV_WAIT = 3'd3;
   localparam logic [2:0] STEP_SKIP_2    = 3'd4;
   localparam logic [2:0] STEP_READ_CMD  = 3'd5;
   localparam logic [2:0] STEP_READ_LOW  = 3'd6;
   localparam logic [2:0] STEP_READ_HIGH = 3'd7;

   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_RST_LOW   = 8'b0000_0010,
      PH_PRES_LOW  = 8'b0000_0100,
      PH_PRES_HIGH = 8'b0000_1000,
      PH_RECOVER   = 8'b0001_0000,
      PH_WRITE     = 8'b0010_0000,
      PH_CONV      = 8'b0100_0000,
      PH_READ      = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic       line_in;
   } req_type;

   typedef struct packed {
      logic               drive_low;
      logic               busy_res;
      logic               done_res;
      logic [1:0]         status;
      logic signed [15:0] temperature;
   } rsp_type;

   typedef struct packed {
      logic [9:0]        reset_low_ticks;
      logic [9:0]        presence_timeout_ticks;
      logic [9:0]        presence_recovery_ticks;
      logic [7:0]        slot_ticks;
      logic [5:0]        read_sample_ticks;
      logic [3:0]        short_low_ticks;
      logic [CONV_W-1:0] conversion_wait_ticks;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/onewire_temperature_read_sequencer_unit.sv
// ---------------------------------------------------------------------------
// onewire_temperature_read_sequencer_unit: one-wire temperature read master
// Runs reset, presence, command and read slots, one input transfer per tick.
// ---------------------------------------------------------------------------
// The result of a tick is registered and is offered in the cycle after its transfer.
// Throughput: one tick per cycle; a stalled result holds off the next transfer.
// Reset is synchronous and active high; the sequencer returns to idle, the
// timing registers take their default values and the output is emptied.
`default_nettype none

module onewire_temperature_read_sequencer_unit
   import owts_pkg::*;
#(
   parameter int COUNT_BITS = 20
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   cfg_type cfg;
   rsp_type result;
   logic    step;

   assign step = req_valid && req_ready;

   owts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   owts_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_data),
      .cfg    (cfg),
      .result (result)
   );

   owts_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .load_data  (result),
      .load_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/owts_csr.sv
// ---------------------------------------------------------------------------
// owts_csr: timing register file
// APB-style write and read access to the seven timing registers.
// ---------------------------------------------------------------------------
`default_nettype none

module owts_csr
   import owts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_RESET_LOW:     cfg_in.reset_low_ticks         = pwdata[9:0];
            REG_PRES_TIMEOUT:  cfg_in.presence_timeout_ticks  = pwdata[9:0];
            REG_PRES_RECOVERY: cfg_in.presence_recovery_ticks = pwdata[9:0];
            REG_SLOT:          cfg_in.slot_ticks              = pwdata[7:0];
            REG_READ_SAMPLE:   cfg_in.read_sample_ticks       = pwdata[5:0];
            REG_SHORT_LOW:     cfg_in.short_low_ticks         = pwdata[3:0];
            REG_CONV_WAIT:     cfg_in.conversion_wait_ticks   = pwdata[CONV_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_RESET_LOW:     prdata = {22'd0, cfg_ff.reset_low_ticks};
         REG_PRES_TIMEOUT:  prdata = {22'd0, cfg_ff.presence_timeout_ticks};
         REG_PRES_RECOVERY: prdata = {22'd0, cfg_ff.presence_recovery_ticks};
         REG_SLOT:          prdata = {24'd0, cfg_ff.slot_ticks};
         REG_READ_SAMPLE:   prdata = {26'd0, cfg_ff.read_sample_ticks};
         REG_SHORT_LOW:     prdata = {28'd0, cfg_ff.short_low_ticks};
         REG_CONV_WAIT:     prdata = {{(DATA_W-CONV_W){1'b0}}, cfg_ff.conversion_wait_ticks};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks         <= RST_RESET_LOW;
         cfg_ff.presence_timeout_ticks  <= RST_PRES_TIMEOUT;
         cfg_ff.presence_recovery_ticks <= RST_PRES_RECOVERY;
         cfg_ff.slot_ticks              <= RST_SLOT;
         cfg_ff.read_sample_ticks       <= RST_READ_SAMPLE;
         cfg_ff.short_low_ticks         <= RST_SHORT_LOW;
         cfg_ff.conversion_wait_ticks   <= RST_CONV_WAIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/owts_core.sv
// ---------------------------------------------------------------------------
// owts_core: bus sequencer state and next-state logic
// Advances the reset, presence, slot and byte sequencing by one tick for
// every accepted transfer and forms the matching result.
// ---------------------------------------------------------------------------
`default_nettype none

module owts_core
   import owts_pkg::*;
#(
   parameter int COUNT_BITS = 20
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  req_type      item,
   input  cfg_type      cfg,
   output rsp_type      result
);

   localparam int CW = (COUNT_BITS + 1 > CONV_W + 1) ? COUNT_BITS + 1 : CONV_W + 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   phase_type              phase_ff, phase_in, phase_cur;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in, cnt_cur;
   logic [2:0]             bit_ff, bit_in;
   logic [2:0]             cmd_ff, cmd_in;
   logic [7:0]             shift_ff, shift_in;
   logic [7:0]             low_ff, low_in;
   logic [15:0]            temp_ff, temp_in;
   logic [1:0]             status_ff, status_in;
   logic                   rreq_ff, rreq_in;
   logic                   start, busy, done, drive, over, fin, byte_done;
   logic [1:0]             fin_status;
   logic [CW-1:0]          wait_n, cnt_ext, cnt_next_ext;
   logic [8:0]             slot_len, sample_pt;

   assign start     = (phase_ff == PH_IDLE)
                      && (item.action == ACT_READ || item.action == ACT_PRESENCE);
   assign phase_cur = start ? PH_RST_LOW : phase_ff;
   assign cnt_cur   = start ? '0 : cnt_ff;

   assign slot_len = {1'b0, cfg.slot_ticks} + {5'd0, cfg.short_low_ticks};
   assign cnt_ext  = CW'(cnt_cur);
   assign cnt_next_ext = cnt_ext + CW'(1);
   assign over = (cnt_next_ext >= wait_n) || (cnt_cur == CNT_MAX);

   always_comb begin
      if (slot_len == 9'd0) begin
         sample_pt = 9'd0;
      end else if ({3'd0, cfg.read_sample_ticks} > slot_len - 9'd1) begin
         sample_pt = slot_len - 9'd1;
      end else begin
         sample_pt = {3'd0, cfg.read_sample_ticks};
      end
   end

   always_comb begin
      unique case (phase_cur)
         PH_RST_LOW:               wait_n = CW'(cfg.reset_low_ticks);
         PH_PRES_LOW, PH_PRES_HIGH: wait_n = CW'(cfg.presence_timeout_ticks);
         PH_RECOVER:               wait_n = CW'(cfg.presence_recovery_ticks);
         PH_WRITE, PH_READ:        wait_n = CW'(slot_len);
         PH_CONV:                  wait_n = CW'(cfg.conversion_wait_ticks);
         default:                  wait_n = '0;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      bit_in     = bit_ff;
      cmd_in     = cmd_ff;
      shift_in   = shift_ff;
      low_in     = low_ff;
      temp_in    = temp_ff;
      status_in  = status_ff;
      rreq_in    = rreq_ff;
      drive      = 1'b0;
      fin        = 1'b0;
      fin_status = STATUS_OK;
      byte_done  = 1'b0;
      done       = 1'b0;

      if (start) begin
         rreq_in  = (item.action == ACT_READ);
         cmd_in   = STEP_NONE;
         cnt_in   = '0;
         phase_in = PH_RST_LOW;
      end
      busy = (phase_in != PH_IDLE);

      unique case (phase_in)
         PH_RST_LOW: begin
            drive = 1'b1;
            if (over) begin
               phase_in = PH_PRES_LOW;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_next_ext[COUNT_BITS-1:0];
            end
         end
         PH_PRES_LOW: begin
            if (!item.line_in) begin
               phase_in = PH_PRES_HIGH;
               cnt_in   = '0;
            end else if (over) begin
               fin        = 1'b1;
               fin_status = STATUS_NO_PRES;
            end else begin
               cnt_in = cnt_next_ext[COUNT_BITS-1:0];
            end
         end
         PH_PRES_HIGH: begin
            if (item.line_in) begin
               phase_in = PH_RECOVER;
               cnt_in   = '0;
            end else if (over) begin
               fin        = 1'b1;
               fin_status = STATUS_PRES_LONG;
            end else begin
               cnt_in = cnt_next_ext[COUNT_BITS-1:0];
            end
         end
         PH_RECOVER: begin
            if (over) begin
               if (!rreq_in) begin
                  fin        = 1'b1;
                  fin_status = STATUS_OK;
               end else begin
                  cmd_in   = (cmd_in == STEP_NONE) ? STEP_SKIP_1 : STEP_SKIP_2;
                  shift_in = CMD_SKIP_ROM;
                  bit_in   = 3'd0;
                  cnt_in   = '0;
                  phase_in = PH_WRITE;
               end
            end else begin
               cnt_in = cnt_next_ext[COUNT_BITS-1:0];
            end
         end
         PH_WRITE: begin
            if (shift_in[0]) begin
               drive = (cnt_ext < CW'(cfg.short_low_ticks));
            end else begin
               drive = (cnt_ext < CW'(cfg.slot_ticks));
            end
            if (over) begin
               shift_in = {1'b0, shift_in[7:1]};
               if (bit_in == 3'd7) begin
                  bit_in    = 3'd0;
                  byte_done = 1'b1;
               end else begin
                  bit_in = bit_in + 3'd1;
                  cnt_in = '0;
               end
            end else begin
               cnt_in = cnt_next_ext[COUNT_BITS-1:0];
            end
         end
         PH_CONV: begin
            if (over) begin
               phase_in = PH_RST_LOW;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_next_ext[COUNT_BITS-1:0];
            end
         end
         PH_READ: begin
            drive = (cnt_ext < CW'(cfg.short_low_ticks));
            if (cnt_ext == CW'(sample_pt)) begin
               shift_in = {item.line_in, shift_in[7:1]};
            end
            if (over) begin
               if (bit_in == 3'd7) begin
                  bit_in    = 3'd0;
                  byte_done = 1'b1;
               end else begin
                  bit_in = bit_in + 3'd1;
                  cnt_in = '0;
               end
            end else begin
               cnt_in = cnt_next_ext[COUNT_BITS-1:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (byte_done) begin
         unique case (cmd_in)
            STEP_SKIP_1: begin
               cmd_in   = STEP_CONVERT;
               shift_in = CMD_CONVERT;
               cnt_in   = '0;
               phase_in = PH_WRITE;
            end
            STEP_CONVERT: begin
               cmd_in   = STEP_CONV_WAIT;
               cnt_in   = '0;
               phase_in = PH_CONV;
            end
            STEP_SKIP_2: begin
               cmd_in   = STEP_READ_CMD;
               shift_in = CMD_READ_PAD;
               cnt_in   = '0;
               phase_in = PH_WRITE;
            end
            STEP_READ_CMD: begin
               cmd_in   = STEP_READ_LOW;
               shift_in = 8'd0;
               cnt_in   = '0;
               phase_in = PH_READ;
            end
            STEP_READ_LOW: begin
               low_in   = shift_in;
               cmd_in   = STEP_READ_HIGH;
               shift_in = 8'd0;
               cnt_in   = '0;
               phase_in = PH_READ;
            end
            default: begin
               temp_in    = {shift_in, low_in};
               fin        = 1'b1;
               fin_status = STATUS_OK;
            end
         endcase
      end

      if (fin) begin
         status_in = fin_status;
         phase_in  = PH_IDLE;
         cnt_in    = '0;
         rreq_in   = 1'b0;
         done      = 1'b1;
      end
   end

   assign result.drive_low   = drive;
   assign result.busy_res    = busy;
   assign result.done_res    = done;
   assign result.status      = status_in;
   assign result.temperature = temp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cnt_ff    <= '0;
         bit_ff    <= 3'd0;
         cmd_ff    <= STEP_NONE;
         shift_ff  <= 8'd0;
         low_ff    <= 8'd0;
         temp_ff   <= 16'd0;
         status_ff <= STATUS_OK;
         rreq_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         bit_ff    <= bit_in;
         cmd_ff    <= cmd_in;
         shift_ff  <= shift_in;
         low_ff    <= low_in;
         temp_ff   <= temp_in;
         status_ff <= status_in;
         rreq_ff   <= rreq_in;
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      step && done |-> busy)
      else $error("Sequence finished without being busy.");

   a_idle_status: assert property (@(posedge clock) disable iff (reset)
      step && !busy |=> $stable(status_ff) && $stable(temp_ff))
      else $error("Status or temperature changed while idle.");

   a_idle_release: assert property (@(posedge clock) disable iff (reset)
      step && !busy |-> !drive && !done)
      else $error("Bus driven while idle.");

endmodule

`default_nettype wire

>>> rtl/owts_out_reg.sv
// ---------------------------------------------------------------------------
// owts_out_reg: result output register
// Holds one result transfer until it is taken and back-pressures the input.
// ---------------------------------------------------------------------------
`default_nettype none

module owts_out_reg
   import owts_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  rsp_type   load_data,
   output logic      load_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);
   assign rsp_valid  = valid_ff;
   assign rsp_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_onewire_temperature_read_sequencer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_onewire_temperature_read_sequencer_unit: one-wire temperature master
// Drives bus ticks through the request channel while a simple sensor model
// answers presence pulses and read slots. Every tick's bus outputs are
// predicted and compared field by field with the result channel. Timing
// registers are written and read back over the APB port between runs, from
// zero counts up to the widest settings, with random stalls on both sides.
// ---------------------------------------------------------------------------

module tb_onewire_temperature_read_sequencer_unit;
   import owts_pkg::*;

   localparam int          TICK_BITS       = 20;
   localparam logic [19:0] TICK_MAX        = '1;
   localparam logic [1:0]  ACT_UNUSED      = 2'd3;
   localparam logic [2:0]  REG_UNMAPPED    = 3'd7;
   localparam int          RSP_HOLD_CYCLES = 300;
   localparam int          CYCLE_LIMIT     = 1000000;
   localparam int          RANDOM_PHASES   = 2;
   localparam int          PHASE_TICKS     = 50;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Predicted sequencer state
   cfg_type     seq_cfg;
   phase_type   seq_phase;
   logic [19:0] seq_ticks;
   logic [2:0]  seq_bit;
   logic [2:0]  seq_step;
   logic [7:0]  seq_shift;
   logic [7:0]  seq_low;
   logic [15:0] seq_temp;
   logic [1:0]  seq_status;
   logic        seq_read_req;
   logic        seq_done;

   // Sensor model answering the bus
   logic        sensor_present;
   int unsigned sensor_delay;
   int unsigned sensor_width;
   logic [15:0] sensor_temp;
   int unsigned sensor_noise;

   rsp_type     bus_outputs_due[$];
   int          errors            = 0;
   int          ticks_checked     = 0;
   int          sequences_done    = 0;
   int          reads_done        = 0;
   int          presence_failures = 0;
   int          timing_settings   = 0;
   int          cycle_count       = 0;
   bit          idle_enabled      = 1'b1;
   bit          rsp_hold_toggle   = 1'b0;
   bit          rsp_hold_seen     = 1'b0;
   int          rsp_hold_left     = 0;

   onewire_temperature_read_sequencer_unit #(
      .COUNT_BITS(TICK_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic bit count_done(input int unsigned limit);
      if ({12'd0, seq_ticks} + 32'd1 >= limit || seq_ticks == TICK_MAX)
         return 1'b1;
      seq_ticks = seq_ticks + 1'b1;
      return 1'b0;
   endfunction

   function automatic void seq_finish(input logic [1:0] code);
      seq_status   = code;
      seq_phase    = PH_IDLE;
      seq_ticks    = '0;
      seq_read_req = 1'b0;
      seq_done     = 1'b1;
      sequences_done++;
      if (code != STATUS_OK)
         presence_failures++;
   endfunction

   function automatic void seq_start_write(input logic [7:0] command);
      seq_shift = command;
      seq_bit   = '0;
      seq_ticks = '0;
      seq_phase = PH_WRITE;
   endfunction

   function automatic void seq_start_read();
      seq_shift = '0;
      seq_bit   = '0;
      seq_ticks = '0;
      seq_phase = PH_READ;
   endfunction

   function automatic void slot_end();
      if (seq_bit == 3'd7) begin
         seq_bit = '0;
         case (seq_step)
            STEP_SKIP_1: begin
               seq_step = STEP_CONVERT;
               seq_start_write(CMD_CONVERT);
            end
            STEP_CONVERT: begin
               seq_step  = STEP_CONV_WAIT;
               seq_phase = PH_CONV;
               seq_ticks = '0;
            end
            STEP_SKIP_2: begin
               seq_step = STEP_READ_CMD;
               seq_start_write(CMD_READ_PAD);
            end
            STEP_READ_CMD: begin
               seq_step = STEP_READ_LOW;
               seq_start_read();
            end
            STEP_READ_LOW: begin
               seq_low  = seq_shift;
               seq_step = STEP_READ_HIGH;
               seq_start_read();
            end
            default: begin
               seq_temp = {seq_shift, seq_low};
               reads_done++;
               seq_finish(STATUS_OK);
            end
         endcase
      end else begin
         seq_bit   = seq_bit + 1'b1;
         seq_ticks = '0;
      end
   endfunction

   function automatic rsp_type sequencer_step(input req_type item);
      rsp_type     outputs;
      logic [19:0] cnt;
      int unsigned span;
      int unsigned sample_at;
      outputs  = '0;
      seq_done = 1'b0;
      if (seq_phase == PH_IDLE && (item.action == ACT_READ || item.action == ACT_PRESENCE)) begin
         seq_read_req = (item.action == ACT_READ);
         seq_step     = STEP_NONE;
         seq_ticks    = '0;
         seq_phase    = PH_RST_LOW;
      end
      outputs.busy_res = (seq_phase != PH_IDLE);
      cnt  = seq_ticks;
      span = seq_cfg.slot_ticks + seq_cfg.short_low_ticks;
      case (seq_phase)
         PH_RST_LOW: begin
            outputs.drive_low = 1'b1;
            if (count_done(seq_cfg.reset_low_ticks)) begin
               seq_phase = PH_PRES_LOW;
               seq_ticks = '0;
            end
         end
         PH_PRES_LOW: begin
            if (!item.line_in) begin
               seq_phase = PH_PRES_HIGH;
               seq_ticks = '0;
            end else if (count_done(seq_cfg.presence_timeout_ticks)) begin
               seq_finish(STATUS_NO_PRES);
            end
         end
         PH_PRES_HIGH: begin
            if (item.line_in) begin
               seq_phase = PH_RECOVER;
               seq_ticks = '0;
            end else if (count_done(seq_cfg.presence_timeout_ticks)) begin
               seq_finish(STATUS_PRES_LONG);
            end
         end
         PH_RECOVER: begin
            if (count_done(seq_cfg.presence_recovery_ticks)) begin
               if (!seq_read_req) begin
                  seq_finish(STATUS_OK);
               end else if (seq_step == STEP_NONE) begin
                  seq_step = STEP_SKIP_1;
                  seq_start_write(CMD_SKIP_ROM);
               end else begin
                  seq_step = STEP_SKIP_2;
                  seq_start_write(CMD_SKIP_ROM);
               end
            end
         end
         PH_WRITE: begin
            if (seq_shift[0])
               outputs.drive_low = (cnt < seq_cfg.short_low_ticks);
            else
               outputs.drive_low = (cnt < seq_cfg.slot_ticks);
            if (count_done(span)) begin
               seq_shift = seq_shift >> 1;
               slot_end();
            end
         end
         PH_CONV: begin
            if (count_done(seq_cfg.conversion_wait_ticks)) begin
               seq_phase = PH_RST_LOW;
               seq_ticks = '0;
            end
         end
         PH_READ: begin
            outputs.drive_low = (cnt < seq_cfg.short_low_ticks);
            sample_at = seq_cfg.read_sample_ticks;
            if (span == 0)
               sample_at = 0;
            else if (sample_at > span - 1)
               sample_at = span - 1;
            if (cnt == sample_at)
               seq_shift = {item.line_in, seq_shift[7:1]};
            if (count_done(span))
               slot_end();
         end
         default: seq_phase = PH_IDLE;
      endcase
      outputs.done_res    = seq_done;
      outputs.status      = seq_status;
      outputs.temperature = seq_temp;
      return outputs;
   endfunction

   function automatic void csr_store(input logic [2:0] index, input logic [31:0] value);
      case (index)
         REG_RESET_LOW:     seq_cfg.reset_low_ticks         = value[9:0];
         REG_PRES_TIMEOUT:  seq_cfg.presence_timeout_ticks  = value[9:0];
         REG_PRES_RECOVERY: seq_cfg.presence_recovery_ticks = value[9:0];
         REG_SLOT:          seq_cfg.slot_ticks              = value[7:0];
         REG_READ_SAMPLE:   seq_cfg.read_sample_ticks       = value[5:0];
         REG_SHORT_LOW:     seq_cfg.short_low_ticks         = value[3:0];
         REG_CONV_WAIT:     seq_cfg.conversion_wait_ticks   = value[CONV_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] csr_value(input logic [2:0] index);
      case (index)
         REG_RESET_LOW:     return 32'(seq_cfg.reset_low_ticks);
         REG_PRES_TIMEOUT:  return 32'(seq_cfg.presence_timeout_ticks);
         REG_PRES_RECOVERY: return 32'(seq_cfg.presence_recovery_ticks);
         REG_SLOT:          return 32'(seq_cfg.slot_ticks);
         REG_READ_SAMPLE:   return 32'(seq_cfg.read_sample_ticks);
         REG_SHORT_LOW:     return 32'(seq_cfg.short_low_ticks);
         REG_CONV_WAIT:     return 32'(seq_cfg.conversion_wait_ticks);
         default:           return '0;
      endcase
   endfunction

   function automatic logic sensor_line();
      logic level;
      case (seq_phase)
         PH_PRES_LOW:  level = !(sensor_present && seq_ticks >= sensor_delay);
         PH_PRES_HIGH: level = (seq_ticks >= sensor_width);
         PH_READ:      level = sensor_temp[{seq_step == STEP_READ_HIGH, seq_bit}];
         default:      level = 1'($urandom_range(1));
      endcase
      if ($urandom_range(99) < sensor_noise)
         level = !level;
      return level;
   endfunction

   function automatic void set_sensor(input logic present, input int unsigned delay,
                                      input int unsigned width, input logic [15:0] temp);
      sensor_present = present;
      sensor_delay   = delay;
      sensor_width   = width;
      sensor_temp    = temp;
      sensor_noise   = 0;
   endfunction

   function automatic void randomise_sensor();
      int unsigned limit;
      limit = seq_cfg.presence_timeout_ticks;
      sensor_present = ($urandom_range(99) < 90);
      sensor_delay   = $urandom_range(limit > 0 ? limit - 1 : 0);
      if ($urandom_range(99) < 15)
         sensor_delay = limit + $urandom_range(2);
      sensor_width = $urandom_range(limit > 0 ? limit - 1 : 0);
      if ($urandom_range(99) < 15)
         sensor_width = limit + $urandom_range(2);
      case ($urandom_range(7))
         0:       sensor_temp = 16'h8000;
         1:       sensor_temp = 16'h7FFF;
         2:       sensor_temp = 16'hFFFF;
         3:       sensor_temp = 16'h0000;
         default: sensor_temp = 16'($urandom);
      endcase
      sensor_noise = ($urandom_range(99) < 20) ? 4 : 0;
   endfunction

   function automatic logic [1:0] busy_action();
      if ($urandom_range(99) < 20)
         return 2'($urandom_range(ACT_UNUSED));
      return ACT_TICK;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch on tick %0d, expected %0h, got %0h",
                  $time, name, ticks_checked, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         ticks_checked++;
         if (bus_outputs_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, rsp_data);
            errors++;
         end else begin
            due = bus_outputs_due.pop_front();
            check_field("drive_low", 16'(due.drive_low), 16'(rsp_data.drive_low));
            check_field("busy_res", 16'(due.busy_res), 16'(rsp_data.busy_res));
            check_field("done_res", 16'(due.done_res), 16'(rsp_data.done_res));
            check_field("status", 16'(due.status), 16'(rsp_data.status));
            check_field("temperature", due.temperature, rsp_data.temperature);
         end
      end
      if (rsp_hold_toggle != rsp_hold_seen) begin
         rsp_hold_seen = rsp_hold_toggle;
         rsp_hold_left = RSP_HOLD_CYCLES;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_enabled && $urandom_range(99) < 23);
      end
   end

   task automatic send_tick(input req_type item);
      while (idle_enabled && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      bus_outputs_due.push_back(sequencer_step(item));
   endtask

   task automatic run_tick(input logic [1:0] action);
      req_type item;
      item.action  = action;
      item.line_in = sensor_line();
      send_tick(item);
   endtask

   task automatic finish_sequence();
      while (seq_phase != PH_IDLE)
         run_tick(busy_action());
   endtask

   task automatic run_sequence(input logic [1:0] action);
      run_tick(action);
      finish_sequence();
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (bus_outputs_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_check(input logic [2:0] index);
      logic [31:0] seen;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready)
         @(negedge clock);
      seen = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (seen !== csr_value(index)) begin
         $display("%0t: register %0d read back, expected %0h, got %0h",
                  $time, index, csr_value(index), seen);
         errors++;
      end
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      csr_store(index, value);
      if (index < REG_COUNT)
         csr_check(index);
   endtask

   task automatic set_timing(input int unsigned reset_low, input int unsigned timeout,
                             input int unsigned recovery, input int unsigned slot,
                             input int unsigned sample, input int unsigned short_low,
                             input int unsigned conv_wait);
      wait_until_drained();
      csr_write(REG_RESET_LOW, reset_low);
      csr_write(REG_PRES_TIMEOUT, timeout);
      csr_write(REG_PRES_RECOVERY, recovery);
      csr_write(REG_SLOT, slot);
      csr_write(REG_READ_SAMPLE, sample);
      csr_write(REG_SHORT_LOW, short_low);
      csr_write(REG_CONV_WAIT, conv_wait);
      timing_settings++;
   endtask

   task automatic test_register_access();
      for (int r = 0; r < REG_COUNT; r++)
         csr_check(3'(r));
      for (int r = 0; r < REG_COUNT; r++)
         csr_write(3'(r), $urandom);
      for (int r = 0; r < REG_COUNT; r++)
         csr_write(3'(r), ~csr_value(3'(r)));
      csr_write(REG_UNMAPPED, $urandom);
      for (int r = 0; r < REG_COUNT; r++)
         csr_check(3'(r));
   endtask

   task automatic test_presence_check();
      set_timing(3, 6, 2, 2, 1, 1, 2);
      run_tick(ACT_UNUSED);
      run_tick(ACT_TICK);
      set_sensor(1'b1, 1, 2, 16'h0000);
      run_sequence(ACT_PRESENCE);
      set_sensor(1'b0, 0, 0, 16'h0000);
      run_sequence(ACT_PRESENCE);
      set_sensor(1'b1, 1, 20, 16'h0000);
      run_sequence(ACT_PRESENCE);
      set_sensor(1'b1, 5, 5, 16'h0000);
      run_sequence(ACT_PRESENCE);
      set_sensor(1'b1, 6, 1, 16'h0000);
      run_sequence(ACT_PRESENCE);
      set_sensor(1'b1, 0, 6, 16'h0000);
      run_sequence(ACT_READ);
   endtask

   task automatic test_temperature_read();
      logic [15:0] patterns[2];
      patterns = '{16'hFC90, 16'h8000};
      set_timing(3, 6, 2, 1, 1, 1, 2);
      idle_enabled = 1'b0;
      foreach (patterns[p]) begin
         set_sensor(1'b1, 0, 1, patterns[p]);
         run_sequence(ACT_READ);
      end
      idle_enabled = 1'b1;
      set_sensor(1'b0, 0, 0, 16'h0000);
      run_sequence(ACT_READ);
   endtask

   task automatic test_zero_timing();
      set_timing(0, 0, 0, 0, 0, 0, 0);
      set_sensor(1'b1, 0, 0, 16'hA55A);
      run_sequence(ACT_READ);
      run_sequence(ACT_PRESENCE);
      set_sensor(1'b0, 0, 0, 16'h0000);
      run_sequence(ACT_PRESENCE);
   endtask

   task automatic test_sample_clamp();
      set_timing(2, 4, 1, 0, 63, 2, 1);
      set_sensor(1'b1, 1, 1, 16'h1234);
      run_sequence(ACT_READ);
   endtask

   // The receiver stops for a long stretch while ticks keep coming, so the
   // block fills and holds off further transfers.
   task automatic test_backpressure();
      set_timing(2, 5, 1, 1, 1, 1, 3);
      set_sensor(1'b1, 1, 1, 16'h0F0F);
      run_tick(ACT_READ);
      idle_enabled    = 1'b0;
      rsp_hold_toggle = !rsp_hold_toggle;
      repeat (80)
         run_tick(ACT_TICK);
      idle_enabled = 1'b1;
      finish_sequence();
   endtask

   task automatic test_drain_pause();
      set_sensor(1'b1, 2, 1, 16'hE6F0);
      run_tick(ACT_READ);
      repeat (30)
         run_tick(busy_action());
      wait_until_drained();
      repeat (30)
         run_tick(busy_action());
      wait_until_drained();
      finish_sequence();
   endtask

   task automatic test_extreme_timing();
      idle_enabled = 1'b0;
      set_timing(3, 1023, 2, 255, 63, 15, 0);
      set_sensor(1'b1, 40, 30, 16'h5A0F);
      run_sequence(ACT_PRESENCE);
      wait_until_drained();
      csr_write(REG_CONV_WAIT, 32'hFFFF_FFFF);
      set_sensor(1'b1, 0, 0, 16'h0000);
      run_sequence(ACT_PRESENCE);
      idle_enabled = 1'b1;
   endtask

   task automatic test_random_sequences();
      int          counted;
      int unsigned pick;
      logic [1:0]  action;
      for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
         set_timing($urandom_range(4), $urandom_range(6), $urandom_range(3),
                    $urandom_range(2), $urandom_range(4), $urandom_range(2),
                    $urandom_range(4));
         counted = 0;
         while (counted < PHASE_TICKS) begin
            if (seq_phase == PH_IDLE) begin
               pick = $urandom_range(99);
               if (pick < 45)
                  action = ACT_READ;
               else if (pick < 70)
                  action = ACT_PRESENCE;
               else if (pick < 80)
                  action = ACT_UNUSED;
               else
                  action = ACT_TICK;
               if (action == ACT_READ || action == ACT_PRESENCE) begin
                  randomise_sensor();
                  counted++;
               end
               run_tick(action);
            end else begin
               counted++;
               run_tick(busy_action());
            end
         end
         finish_sequence();
      end
   endtask

   initial begin
      seq_cfg.reset_low_ticks         = RST_RESET_LOW;
      seq_cfg.presence_timeout_ticks  = RST_PRES_TIMEOUT;
      seq_cfg.presence_recovery_ticks = RST_PRES_RECOVERY;
      seq_cfg.slot_ticks              = RST_SLOT;
      seq_cfg.read_sample_ticks       = RST_READ_SAMPLE;
      seq_cfg.short_low_ticks         = RST_SHORT_LOW;
      seq_cfg.conversion_wait_ticks   = RST_CONV_WAIT;
      seq_phase    = PH_IDLE;
      seq_ticks    = '0;
      seq_bit      = '0;
      seq_step     = STEP_NONE;
      seq_shift    = '0;
      seq_low      = '0;
      seq_temp     = '0;
      seq_status   = STATUS_OK;
      seq_read_req = 1'b0;
      seq_done     = 1'b0;
      set_sensor(1'b1, 0, 0, 16'h0000);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_presence_check();
      test_temperature_read();
      test_zero_timing();
      test_sample_clamp();
      test_backpressure();
      test_drain_pause();
      test_extreme_timing();
      test_random_sequences();

      wait_until_drained();
      repeat (10) @(posedge clock);
      $display("Ran register access, presence checks, reads and random traffic over %0d settings.",
               timing_settings);
      $display("Checked %0d ticks: %0d sequences, %0d temperature reads, %0d presence failures.",
               ticks_checked, sequences_done, reads_done, presence_failures);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
